>>> design/mrhrs_pkg.sv
// Shared types and constants of the mixer ramp/hold/reverse sequencer.
package mrhrs_pkg;

  localparam int unsigned SpeedW    = 8;
  localparam int unsigned IntervalW = 8;
  localparam int unsigned StepsW    = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned InDataW   = 16;
  localparam int unsigned OutDataW  = 16;

  localparam logic [IntervalW-1:0] RampIntervalReset = 8'd30;
  localparam logic [IntervalW-1:0] HoldIntervalReset = 8'd10;
  localparam logic [StepsW-1:0]    HoldStepsReset    = 16'd1000;
  localparam logic [IntervalW-1:0] TicksMax          = 8'd255;
  localparam logic [SpeedW-1:0]    SpeedMin          = 8'd1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RAMP_INTERVAL = 2'd0,
    REG_HOLD_INTERVAL = 2'd1,
    REG_HOLD_STEPS    = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [IntervalW-1:0] ramp_interval_ms;
    logic [IntervalW-1:0] hold_interval_ms;
    logic [StepsW-1:0]    hold_steps;
  } cfg_t;

  typedef struct packed {
    logic              mix_request;
    logic [SpeedW-1:0] speed_request;
  } item_t;

  typedef struct packed {
    logic              drive_strobe;
    logic [SpeedW-1:0] drive_speed;
    logic              drive_direction;
    logic              motor_stop;
    logic              mixing_active;
  } result_t;

endpackage

>>> design/mrhrs_cfg.sv
// Configuration register file of the mixer sequencer.
module mrhrs_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mrhrs_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [mrhrs_pkg::CfgDataW-1:0]      cfg_data,
  output mrhrs_pkg::cfg_t                     cfg
);

  mrhrs_pkg::cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.ramp_interval_ms <= mrhrs_pkg::RampIntervalReset;
      regs.hold_interval_ms <= mrhrs_pkg::HoldIntervalReset;
      regs.hold_steps       <= mrhrs_pkg::HoldStepsReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mrhrs_pkg::REG_RAMP_INTERVAL: begin
          regs.ramp_interval_ms <= cfg_data[mrhrs_pkg::IntervalW-1:0];
        end
        mrhrs_pkg::REG_HOLD_INTERVAL: begin
          regs.hold_interval_ms <= cfg_data[mrhrs_pkg::IntervalW-1:0];
        end
        mrhrs_pkg::REG_HOLD_STEPS: begin
          regs.hold_steps <= cfg_data[mrhrs_pkg::StepsW-1:0];
        end
        default: begin
          regs <= regs;
        end
      endcase
    end
  end

endmodule

>>> design/mrhrs_step.sv
// Sequencer state and the per-tick ramp, hold and reverse logic.
module mrhrs_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  mrhrs_pkg::item_t   item,
  input  mrhrs_pkg::cfg_t    cfg,
  output mrhrs_pkg::result_t result
);

  logic [mrhrs_pkg::SpeedW-1:0]    ramp_speed, ramp_speed_next;
  logic [mrhrs_pkg::StepsW-1:0]    hold_count, hold_count_next;
  logic                            spin_direction, spin_direction_next;
  logic [mrhrs_pkg::SpeedW-1:0]    speed_setpoint, speed_setpoint_next;
  logic [mrhrs_pkg::IntervalW-1:0] ticks_since_step, ticks_since_step_next;
  logic [mrhrs_pkg::IntervalW-1:0] ticks_inc;

  always_comb begin
    // The tick counter saturates, so the first step after reset fires at once.
    ticks_inc = (ticks_since_step != mrhrs_pkg::TicksMax) ?
                ticks_since_step + 8'd1 : ticks_since_step;

    ramp_speed_next       = ramp_speed;
    hold_count_next       = hold_count;
    spin_direction_next   = spin_direction;
    speed_setpoint_next   = speed_setpoint;
    ticks_since_step_next = ticks_inc;
    result                = '0;
    result.mixing_active  = item.mix_request;

    if (item.mix_request) begin
      if (ramp_speed < speed_setpoint && hold_count == '0) begin
        if (ticks_inc >= cfg.ramp_interval_ms) begin
          ticks_since_step_next  = '0;
          result.drive_strobe    = 1'b1;
          result.drive_speed     = ramp_speed;
          result.drive_direction = spin_direction;
          ramp_speed_next        = ramp_speed + 8'd1;
        end
      end else if (ramp_speed == speed_setpoint && hold_count < cfg.hold_steps) begin
        if (ticks_inc >= cfg.hold_interval_ms) begin
          ticks_since_step_next  = '0;
          result.drive_strobe    = 1'b1;
          result.drive_speed     = ramp_speed;
          result.drive_direction = spin_direction;
          hold_count_next        = hold_count + 16'd1;
        end
      end else if (ramp_speed > mrhrs_pkg::SpeedMin && hold_count == cfg.hold_steps) begin
        if (ticks_inc >= cfg.ramp_interval_ms) begin
          ticks_since_step_next  = '0;
          result.drive_strobe    = 1'b1;
          result.drive_speed     = ramp_speed;
          result.drive_direction = spin_direction;
          ramp_speed_next        = ramp_speed - 8'd1;
        end
      end else begin
        // Cycle finished (or zero setpoint): restart and reverse.
        ramp_speed_next     = mrhrs_pkg::SpeedMin;
        hold_count_next     = '0;
        spin_direction_next = ~spin_direction;
      end
    end else if (hold_count != '0 || ramp_speed != mrhrs_pkg::SpeedMin) begin
      hold_count_next   = '0;
      ramp_speed_next   = mrhrs_pkg::SpeedMin;
      result.motor_stop = 1'b1;
    end else begin
      speed_setpoint_next = item.speed_request;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_speed       <= mrhrs_pkg::SpeedMin;
      hold_count       <= '0;
      spin_direction   <= 1'b1;
      speed_setpoint   <= '0;
      ticks_since_step <= mrhrs_pkg::TicksMax;
    end else if (advance) begin
      ramp_speed       <= ramp_speed_next;
      hold_count       <= hold_count_next;
      spin_direction   <= spin_direction_next;
      speed_setpoint   <= speed_setpoint_next;
      ticks_since_step <= ticks_since_step_next;
    end
  end

endmodule

>>> design/mixer_ramp_hold_reverse_sequencer.sv
// Path from input transaction to result: input register, then result register.
// Throughput: one tick item per clock cycle while m_axis_tready holds; the state updates once per accepted item.
// Each accepted item yields exactly one result transaction.
// Reset (synchronous, rst high) empties both registers, restores the configuration
// defaults and returns the sequencer to speed 1, forward direction, zero setpoint.
module mixer_ramp_hold_reverse_sequencer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [0] mix_request, [8:1] speed_request, [15:9] ignored
  input  logic [mrhrs_pkg::InDataW-1:0]        s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [0] drive_strobe, [8:1] drive_speed, [9] drive_direction, [10] motor_stop,
  // [11] mixing_active, [15:12] zero
  output logic [mrhrs_pkg::OutDataW-1:0]       m_axis_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mrhrs_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [mrhrs_pkg::CfgDataW-1:0]       cfg_data
);

  mrhrs_pkg::cfg_t    cfg;
  mrhrs_pkg::item_t   in_item;
  logic               in_valid;
  mrhrs_pkg::result_t step_result;
  mrhrs_pkg::result_t out_result;
  logic               out_valid;
  logic               out_free;
  logic               advance;

  // The result register is free when empty or being drained this cycle.
  assign out_free      = !out_valid || m_axis_tready;
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  mrhrs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mrhrs_step u_step (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .cfg     (cfg),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.mix_request   <= s_axis_tdata[0];
      in_item.speed_request <= s_axis_tdata[mrhrs_pkg::SpeedW:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000,
                          out_result.mixing_active,
                          out_result.motor_stop,
                          out_result.drive_direction,
                          out_result.drive_speed,
                          out_result.drive_strobe};

endmodule
